// ===== rtl/assert_macros.svh =====
// Assertion macros included by the accumulator top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, clocked on clk, off during reset
`define ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on clk, off during reset
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/mtaa_pkg.sv =====
// Package: widths, constants and gain table of the multi-turn angle accumulator
`default_nettype none

package mtaa_pkg;

    localparam int NUM_MOTORS_DEF = 16;

    localparam int IDX_W    = 4;
    localparam int ANGLE_W  = 13;
    localparam int SPEED_W  = 16;
    localparam int SUM_W    = 48;
    localparam int INC_W    = 34;
    localparam int DELTA_W  = 15;
    localparam int GAIN_W   = 21;
    localparam int TYPES_W  = 32;
    localparam int IDX_EXT_W = 7;

    localparam logic [DELTA_W-1:0] TURN_COUNTS = 15'd8192;
    localparam logic [DELTA_W-1:0] WRAP_LIMIT  = 15'd1250;

    // Motor type codes held two bits per motor in the type register
    localparam logic [1:0] TYPE_RATIO_19 = 2'd0;
    localparam logic [1:0] TYPE_RATIO_36 = 2'd1;
    localparam logic [1:0] TYPE_RATIO_1  = 2'd2;
    localparam logic [1:0] TYPE_UNKNOWN  = 2'd3;

    // Gain per count in 2^-24 degree: round(360 * 2^24 / 8192 / ratio)
    function automatic logic [GAIN_W-1:0] gain_of(input logic [1:0] type_code);
        logic [GAIN_W-1:0] g;
        case (type_code)
            TYPE_RATIO_19: g = 21'd38804;
            TYPE_RATIO_36: g = 21'd20480;
            TYPE_RATIO_1:  g = 21'd737280;
            TYPE_UNKNOWN:  g = 21'd0;
            default:       g = 21'd0;
        endcase
        return g;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/multi_turn_angle_accumulator.sv =====
// Top level: per-motor multi-turn angle unwrap and saturating accumulation
// An accepted item passes the stage 1, stage 2 and output registers in turn.
// Throughput: one item per cycle unless the output stalls; delta and multiply, then
// add and write back, each take one stage, with the state memory read at acceptance.
// Forwarding from the add stage and the write-back stage covers items on one motor.
// Reset clears the primed bits, the type register and the pipeline valids; the
// state memory needs no clearing pass, an unprimed motor reads as zero.
`default_nettype none

module multi_turn_angle_accumulator #(
    parameter int NUM_MOTORS = mtaa_pkg::NUM_MOTORS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output      logic        s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // rotor_angle[12:0], rotor_speed[28:13]
    input  wire logic [3:0]  s_axis_tuser,   // motor_index[3:0]
    output      logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output      logic [87:0] m_axis_tdata,   // total_angle[47:0], step_increment[81:48]
    output      logic [1:0]  m_axis_tuser,   // wrap_rejected[0], was_priming[1]
    input  wire logic        cfg_valid,
    output      logic        cfg_ready,
    input  wire logic [31:0] cfg_data
);

    localparam int AW    = (NUM_MOTORS > 1) ? $clog2(NUM_MOTORS) : 1;
    localparam int REC_W = mtaa_pkg::ANGLE_W + mtaa_pkg::SUM_W;

    typedef logic [mtaa_pkg::IDX_W-1:0]   idx_t;
    typedef logic [mtaa_pkg::ANGLE_W-1:0] angle_t;
    typedef logic signed [mtaa_pkg::SUM_W-1:0]   sum_t;
    typedef logic signed [mtaa_pkg::INC_W-1:0]   inc_t;
    typedef logic signed [mtaa_pkg::DELTA_W-1:0] delta_t;

    localparam sum_t SUM_MAX = {1'b0, {(mtaa_pkg::SUM_W-1){1'b1}}};
    localparam sum_t SUM_MIN = {1'b1, {(mtaa_pkg::SUM_W-1){1'b0}}};

    // ---------------- configuration ----------------
    logic [mtaa_pkg::TYPES_W-1:0] motor_types_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            motor_types_reg <= '0;
        end
        else if (cfg_valid)
        begin
            motor_types_reg <= cfg_data;
        end
    end

    // ---------------- pipeline control ----------------
    logic out_valid_reg;
    logic advance;
    logic in_fire;

    assign advance       = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = advance;
    assign in_fire       = s_axis_tvalid && advance;

    // ---------------- state memory ----------------
    logic [REC_W-1:0]      state_mem [NUM_MOTORS];
    logic [REC_W-1:0]      rd_data_reg;
    logic [NUM_MOTORS-1:0] primed_reg;

    logic [mtaa_pkg::IDX_EXT_W-1:0] in_idx_ext;
    logic [AW-1:0]                  rd_addr;

    assign in_idx_ext = {3'b000, s_axis_tuser};
    assign rd_addr    = in_idx_ext[AW-1:0];

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [REC_W-1:0] wr_data;

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            rd_data_reg <= state_mem[rd_addr];
        end
        if (wr_en)
        begin
            state_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            primed_reg <= '0;
        end
        else if (wr_en)
        begin
            primed_reg[wr_addr] <= 1'b1;
        end
    end

    // ---------------- stage 1: forward, delta, multiply ----------------
    logic   s1_valid_reg;
    idx_t   s1_idx_reg;
    angle_t s1_angle_reg;
    logic [mtaa_pkg::SPEED_W-1:0] s1_speed_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_idx_reg   <= s_axis_tuser;
            s1_angle_reg <= s_axis_tdata[12:0];
            s1_speed_reg <= s_axis_tdata[28:13];
        end
    end

    // stage 2 and write-back registers, declared here for forwarding
    logic   s2_valid_reg;
    logic   s2_inr_reg;
    idx_t   s2_idx_reg;
    angle_t s2_angle_reg;
    sum_t   s2_base_reg;
    inc_t   s2_inc_reg;
    logic   s2_rej_reg;
    logic   s2_prime_reg;
    sum_t   s2_sum;

    logic   wb_en_reg;
    idx_t   wb_idx_reg;
    angle_t wb_angle_reg;
    sum_t   out_total_reg;
    inc_t   out_inc_reg;
    logic   out_rej_reg;
    logic   out_prime_reg;

    logic [mtaa_pkg::IDX_EXT_W-1:0] s1_idx_ext;
    logic [AW-1:0] s1_addr;
    logic          s1_inr;
    logic          hit_s2;
    logic          hit_wb;
    angle_t        prev_angle;
    sum_t          prev_sum;
    logic          prev_primed;
    delta_t        diff;
    delta_t        fwd_wrap;
    delta_t        bwd_wrap;
    delta_t        delta;
    logic          rejected;
    logic          speed_pos;
    logic          speed_neg;
    logic [1:0]    type_code;
    logic [mtaa_pkg::GAIN_W-1:0] gain;
    logic signed [mtaa_pkg::DELTA_W+mtaa_pkg::GAIN_W:0] product;

    logic s2_inr_next;
    sum_t s2_base_next;
    inc_t s2_inc_next;
    logic s2_rej_next;
    logic s2_prime_next;

    assign s1_idx_ext = {3'b000, s1_idx_reg};
    assign s1_addr    = s1_idx_ext[AW-1:0];
    assign s1_inr     = s1_idx_ext < mtaa_pkg::IDX_EXT_W'(NUM_MOTORS);
    assign hit_s2     = s2_valid_reg && s2_inr_reg && (s2_idx_reg == s1_idx_reg);
    assign hit_wb     = wb_en_reg && (wb_idx_reg == s1_idx_reg);

    always_comb
    begin
        // newest copy of this motor's record: add stage, then last write, then memory
        if (hit_s2)
        begin
            prev_angle  = s2_angle_reg;
            prev_sum    = s2_sum;
            prev_primed = 1'b1;
        end
        else if (hit_wb)
        begin
            prev_angle  = wb_angle_reg;
            prev_sum    = out_total_reg;
            prev_primed = 1'b1;
        end
        else
        begin
            prev_angle  = rd_data_reg[REC_W-1:mtaa_pkg::SUM_W];
            prev_sum    = rd_data_reg[mtaa_pkg::SUM_W-1:0];
            prev_primed = primed_reg[s1_addr];
        end
    end

    always_comb
    begin
        diff      = $signed({2'b00, s1_angle_reg}) - $signed({2'b00, prev_angle});
        fwd_wrap  = diff + $signed(mtaa_pkg::TURN_COUNTS);
        bwd_wrap  = $signed(mtaa_pkg::TURN_COUNTS) - diff;
        speed_pos = (s1_speed_reg != '0) && !s1_speed_reg[mtaa_pkg::SPEED_W-1];
        speed_neg = s1_speed_reg[mtaa_pkg::SPEED_W-1];
        delta     = diff;
        rejected  = 1'b0;
        if (!prev_primed)
        begin
            delta = '0;
        end
        else if (speed_pos && diff[mtaa_pkg::DELTA_W-1])
        begin
            // forward move through the 8191/0 boundary
            if (fwd_wrap < $signed(mtaa_pkg::WRAP_LIMIT))
            begin
                delta = fwd_wrap;
            end
            else
            begin
                delta    = '0;
                rejected = 1'b1;
            end
        end
        else if (speed_neg && !diff[mtaa_pkg::DELTA_W-1] && (diff != '0))
        begin
            // backward move through the boundary
            if (bwd_wrap < $signed(mtaa_pkg::WRAP_LIMIT))
            begin
                delta = -bwd_wrap;
            end
            else
            begin
                delta    = '0;
                rejected = 1'b1;
            end
        end
    end

    assign type_code  = motor_types_reg[{s1_idx_reg, 1'b0} +: 2];
    assign gain       = mtaa_pkg::gain_of(type_code);
    assign product    = delta * $signed({1'b0, gain});

    assign s2_inr_next   = s1_inr;
    assign s2_base_next  = prev_primed ? prev_sum : '0;
    assign s2_inc_next   = product[mtaa_pkg::INC_W-1:0];
    assign s2_rej_next   = rejected;
    assign s2_prime_next = !prev_primed;

    // ---------------- stage 2: saturating add ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s2_inr_reg   <= s2_inr_next;
            s2_idx_reg   <= s1_idx_reg;
            s2_angle_reg <= s1_angle_reg;
            s2_base_reg  <= s2_base_next;
            s2_inc_reg   <= s2_inc_next;
            s2_rej_reg   <= s2_rej_next;
            s2_prime_reg <= s2_prime_next;
        end
    end

    logic signed [mtaa_pkg::SUM_W:0] sum_wide;

    assign sum_wide = $signed({s2_base_reg[mtaa_pkg::SUM_W-1], s2_base_reg})
                    + $signed({{(mtaa_pkg::SUM_W-mtaa_pkg::INC_W+1){s2_inc_reg[mtaa_pkg::INC_W-1]}},
                               s2_inc_reg});

    always_comb
    begin
        if (sum_wide[mtaa_pkg::SUM_W] != sum_wide[mtaa_pkg::SUM_W-1])
        begin
            s2_sum = sum_wide[mtaa_pkg::SUM_W] ? SUM_MIN : SUM_MAX;
        end
        else
        begin
            s2_sum = sum_wide[mtaa_pkg::SUM_W-1:0];
        end
    end

    logic [mtaa_pkg::IDX_EXT_W-1:0] s2_idx_ext;

    assign s2_idx_ext = {3'b000, s2_idx_reg};
    assign wr_en      = advance && s2_valid_reg && s2_inr_reg;
    assign wr_addr    = s2_idx_ext[AW-1:0];
    assign wr_data    = {s2_angle_reg, s2_sum};

    // ---------------- output and write-back registers ----------------
    logic wb_en_next;
    sum_t out_total_next;
    inc_t out_inc_next;
    logic out_rej_next;
    logic out_prime_next;

    assign wb_en_next     = s2_valid_reg && s2_inr_reg;
    // a motor beyond the memory gives an all-zero item
    assign out_total_next = s2_inr_reg ? s2_sum : '0;
    assign out_inc_next   = s2_inr_reg ? s2_inc_reg : '0;
    assign out_rej_next   = s2_inr_reg && s2_rej_reg;
    assign out_prime_next = s2_inr_reg && s2_prime_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            wb_en_reg     <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= s2_valid_reg;
            wb_en_reg     <= wb_en_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            wb_idx_reg    <= s2_idx_reg;
            wb_angle_reg  <= s2_angle_reg;
            out_total_reg <= out_total_next;
            out_inc_reg   <= out_inc_next;
            out_rej_reg   <= out_rej_next;
            out_prime_reg <= out_prime_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'b000000, out_inc_reg, out_total_reg};
    assign m_axis_tuser  = {out_prime_reg, out_rej_reg};

    // ---------------- assertions ----------------
    `include "assert_macros.svh"

    `ASSERT_NOW(a_prime_no_step, out_valid_reg && out_prime_reg,
                (out_inc_reg == '0) && !out_rej_reg, "priming item carries a step")
    `ASSERT_NOW(a_reject_no_step, out_valid_reg && out_rej_reg,
                (out_inc_reg == '0) && !out_prime_reg, "dropped wrap carries a step")
    `ASSERT_NEXT(a_write_sets_primed, wr_en,
                 primed_reg[$past(wr_addr)], "written motor not marked primed")
    `ASSERT_NOW(a_wb_matches_out, wb_en_reg, out_valid_reg,
                "write-back forward without a matching item")

endmodule

`default_nettype wire

// ===== tb/sv/multi_turn_angle_accumulator_tb.sv =====
// Testbench: multi-turn angle accumulator, checked against its own unwrap predictor
`timescale 1ns / 100ps

module multi_turn_angle_accumulator_tb;

    localparam int NUM_MOTORS = 16;
    localparam int ANGLE_SPAN = 8192;
    localparam int WRAP_MAX   = 1250;
    localparam longint GAIN_RATIO_19 = 38804;
    localparam longint GAIN_RATIO_36 = 20480;
    localparam longint GAIN_RATIO_1  = 737280;
    localparam longint SHAFT_MAX = 64'sd140737488355327;
    localparam longint SHAFT_MIN = -SHAFT_MAX - 1;
    localparam int SAT_PAIRS = 8;

    typedef struct {
        logic signed [mtaa_pkg::SUM_W-1:0] total_angle;
        logic signed [mtaa_pkg::INC_W-1:0] step_increment;
        logic                              wrap_rejected;
        logic                              was_priming;
    } shaft_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;
    logic [3:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [87:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [31:0] cfg_data = '0;

    // predictor state
    logic [mtaa_pkg::ANGLE_W-1:0] stored_angle [NUM_MOTORS];
    bit                           seen_sample [NUM_MOTORS];
    longint                       shaft_sum [NUM_MOTORS];
    logic [mtaa_pkg::TYPES_W-1:0] type_map;

    shaft_result_t pending_results [$];

    int fail_count = 0;
    int results_checked = 0;
    int samples_sent = 0;
    int cfg_writes = 0;
    int rejected_wraps = 0;
    int clamp_hits = 0;
    int hold_request = 0;
    int burst_left = 0;
    bit gaps_on = 1'b1;
    logic [mtaa_pkg::IDX_W-1:0] prev_motor = '0;

    multi_turn_angle_accumulator #(
        .NUM_MOTORS(NUM_MOTORS)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    initial
    begin
        #30ms;
        $display("Timed out waiting for the block");
        $display("== FAIL ==");
        $finish;
    end

    // Unwrap one sample and update the per-motor state
    function automatic shaft_result_t unwrap_step(input logic [mtaa_pkg::IDX_W-1:0] motor,
                                                  input logic [mtaa_pkg::ANGLE_W-1:0] angle,
                                                  input logic signed [mtaa_pkg::SPEED_W-1:0] speed);
        shaft_result_t r;
        int cur;
        int prv;
        int wrap;
        int move;
        longint gain;
        longint inc;
        longint total;
        logic [1:0] kind;
        r.total_angle = '0;
        r.step_increment = '0;
        r.wrap_rejected = 1'b0;
        r.was_priming = 1'b0;
        if (!seen_sample[motor])
        begin
            seen_sample[motor] = 1'b1;
            stored_angle[motor] = angle;
            r.total_angle = shaft_sum[motor][mtaa_pkg::SUM_W-1:0];
            r.was_priming = 1'b1;
            return r;
        end
        cur = int'(angle);
        prv = int'(stored_angle[motor]);
        move = 0;
        if (speed > 0)
        begin
            if (cur < prv)
            begin
                wrap = ANGLE_SPAN + cur - prv;
                if (wrap < WRAP_MAX) move = wrap;
                else r.wrap_rejected = 1'b1;
            end
            else
                move = cur - prv;
        end
        else if (speed < 0)
        begin
            if (cur > prv)
            begin
                wrap = ANGLE_SPAN - cur + prv;
                if (wrap < WRAP_MAX) move = -wrap;
                else r.wrap_rejected = 1'b1;
            end
            else
                move = cur - prv;
        end
        else
            move = cur - prv;
        kind = type_map[2*motor +: 2];
        case (kind)
            mtaa_pkg::TYPE_RATIO_19: gain = GAIN_RATIO_19;
            mtaa_pkg::TYPE_RATIO_36: gain = GAIN_RATIO_36;
            mtaa_pkg::TYPE_RATIO_1:  gain = GAIN_RATIO_1;
            default:                 gain = 0;
        endcase
        inc = longint'(move) * gain;
        total = shaft_sum[motor] + inc;
        if (total > SHAFT_MAX)
        begin
            total = SHAFT_MAX;
            clamp_hits++;
        end
        if (total < SHAFT_MIN)
        begin
            total = SHAFT_MIN;
            clamp_hits++;
        end
        if (r.wrap_rejected) rejected_wraps++;
        shaft_sum[motor] = total;
        stored_angle[motor] = angle;
        r.total_angle = total[mtaa_pkg::SUM_W-1:0];
        r.step_increment = inc[mtaa_pkg::INC_W-1:0];
        return r;
    endfunction

    function automatic void check_field(input string field, input longint want,
                                        input longint got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", field, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge clk)
    begin
        shaft_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result item with no sample outstanding");
                fail_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("total_angle", want.total_angle, $signed(m_axis_tdata[47:0]));
                check_field("step_increment", want.step_increment,
                            $signed(m_axis_tdata[81:48]));
                check_field("wrap_rejected", want.wrap_rejected, m_axis_tuser[0]);
                check_field("was_priming", want.was_priming, m_axis_tuser[1]);
                results_checked++;
            end
        end
    end

    // Output side: rotating stall patterns, all-ready stretches, long hold on request
    initial
    begin
        int hold_left;
        int stretch_left;
        logic [7:0] pattern;
        hold_left = 0;
        stretch_left = 0;
        pattern = 8'hFF;
        forever
        begin
            @(posedge clk);
            if (hold_request != 0)
            begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                if (stretch_left == 0)
                begin
                    stretch_left = $urandom_range(16, 160);
                    if ($urandom_range(0, 2) == 0) pattern = 8'hFF;
                    else pattern = 8'($urandom_range(1, 255));
                end
                stretch_left--;
                m_axis_tready <= pattern[0];
                pattern = {pattern[0], pattern[7:1]};
            end
        end
    end

    task automatic send_sample(input logic [mtaa_pkg::IDX_W-1:0] motor,
                               input logic [mtaa_pkg::ANGLE_W-1:0] angle,
                               input logic signed [mtaa_pkg::SPEED_W-1:0] speed);
        if (gaps_on)
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 48);
                s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
            burst_left--;
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, speed, angle};
        s_axis_tuser  <= motor;
        do @(posedge clk); while (!s_axis_tready);
        pending_results.push_back(unwrap_step(motor, angle, speed));
        samples_sent++;
        prev_motor = motor;
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (pending_results.size() != 0) @(posedge clk);
    endtask

    task automatic write_motor_types(input logic [mtaa_pkg::TYPES_W-1:0] value);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        type_map = value;
        cfg_writes++;
    endtask

    // Moves from the last angle, small, near the wrap limit or anywhere, and some noise
    task automatic send_random_sample();
        logic [mtaa_pkg::IDX_W-1:0] motor;
        logic [mtaa_pkg::ANGLE_W-1:0] angle;
        logic signed [mtaa_pkg::SPEED_W-1:0] speed;
        int d;
        int mag;
        int pick;
        if ($urandom_range(0, 9) < 4) motor = prev_motor;
        else motor = mtaa_pkg::IDX_W'($urandom_range(0, NUM_MOTORS - 1));
        if ($urandom_range(0, 9) < 7 && seen_sample[motor])
        begin
            case ($urandom_range(0, 2))
                0:       d = $urandom_range(0, 200);
                1:       d = $urandom_range(1150, 1350);
                default: d = $urandom_range(0, 8191);
            endcase
            if ($urandom_range(0, 1) == 1) d = -d;
            angle = mtaa_pkg::ANGLE_W'(((int'(stored_angle[motor]) + d) % ANGLE_SPAN
                                        + ANGLE_SPAN) % ANGLE_SPAN);
            mag = $urandom_range(1, 32767);
            pick = $urandom_range(0, 9);
            if (d == 0) d = ($urandom_range(0, 1) == 1) ? 1 : -1;
            if (pick == 0) speed = '0;
            else if ((pick == 1) != (d > 0)) speed = mtaa_pkg::SPEED_W'(mag);
            else speed = mtaa_pkg::SPEED_W'(-mag);
            if ($urandom_range(0, 15) == 0) speed = (speed < 0) ? 16'sh8000 : 16'sh7FFF;
        end
        else
        begin
            angle = mtaa_pkg::ANGLE_W'($urandom_range(0, ANGLE_SPAN - 1));
            speed = 16'($urandom());
        end
        send_sample(motor, angle, speed);
    endtask

    // Priming, plain moves, wrap limits either way, zero speed, unknown type
    task automatic test_directed_moves();
        write_motor_types(32'hE4E4_E4E4);
        send_sample(4'd0, 13'd8191, 16'sd0);
        send_sample(4'd0, 13'd100, 16'sd1);
        send_sample(4'd0, 13'd1349, 16'sd32767);
        send_sample(4'd0, 13'd99, 16'sd5);
        send_sample(4'd1, 13'd8000, 16'sd5);
        send_sample(4'd1, 13'd1057, 16'sd1);
        send_sample(4'd1, 13'd8000, -16'sd1);
        send_sample(4'd1, 13'd1058, 16'sd32767);
        send_sample(4'd1, 13'd8000, -16'sd32768);
        send_sample(4'd1, 13'd0, 16'sd0);
        send_sample(4'd1, 13'd8191, 16'sd0);
        send_sample(4'd1, 13'd0, -16'sd7);
        send_sample(4'd1, 13'd0, 16'sd3);
        send_sample(4'd2, 13'd0, -16'sd1);
        send_sample(4'd2, 13'd8191, 16'sd1);
        send_sample(4'd2, 13'd0, 16'sd1);
        send_sample(4'd3, 13'd4096, 16'sd2);
        send_sample(4'd3, 13'd5000, 16'sd2);
        send_sample(4'd3, 13'd0, 16'sd9);
        send_sample(4'd15, 13'd1, -16'sd32768);
        send_sample(4'd15, 13'd8191, -16'sd1);
    endtask

    task automatic test_type_settings();
        logic [mtaa_pkg::TYPES_W-1:0] settings [5];
        settings[0] = 32'h0000_0000;
        settings[1] = 32'hFFFF_FFFF;
        settings[2] = 32'h5555_5555;
        settings[3] = $urandom();
        settings[4] = $urandom();
        foreach (settings[i])
        begin
            write_motor_types(settings[i]);
            repeat (70) send_random_sample();
        end
    endtask

    // Output held off for a long stretch while samples keep coming
    task automatic test_output_stall();
        hold_request = 300;
        gaps_on = 1'b0;
        repeat (60) send_random_sample();
        gaps_on = 1'b1;
    endtask

    // Full-gain wraps and near full-turn moves, one motor forward and one backward
    task automatic test_saturation();
        write_motor_types(32'hAAAA_AAAA);
        gaps_on = 1'b0;
        for (int i = 0; i < SAT_PAIRS; i++)
        begin
            send_sample(4'd14, 13'd8191, 16'sd1);
            send_sample(4'd14, 13'd0, 16'sd1);
            send_sample(4'd15, 13'd0, -16'sd1);
            send_sample(4'd15, 13'd8191, -16'sd1);
        end
        gaps_on = 1'b1;
    endtask

    initial
    begin
        for (int m = 0; m < NUM_MOTORS; m++)
        begin
            stored_angle[m] = '0;
            seen_sample[m] = 1'b0;
            shaft_sum[m] = 0;
        end
        type_map = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_moves();
        test_type_settings();
        test_output_stall();
        test_saturation();
        drain_results();
        repeat (8) @(posedge clk);
        $display("Sent %0d samples over %0d type settings; %0d results checked",
                 samples_sent, cfg_writes, results_checked);
        $display("Dropped wraps seen: %0d, clamped sums seen: %0d", rejected_wraps, clamp_hits);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/mtaa_pkg.sv
rtl/multi_turn_angle_accumulator.sv
tb/sv/multi_turn_angle_accumulator_tb.sv
